### sv/ssca_pkg.sv
package ssca_pkg;

  localparam int NumChunksDef  = 256;
  localparam int NumListsDef   = 256;
  localparam int ChunkLog2Def  = 19;

  localparam int FuncW    = 3;
  localparam int ReqW     = 28;
  localparam int OffW     = 27;
  localparam int BytesW   = 28;
  localparam int StartW   = 8;
  localparam int StatusW  = 3;
  localparam int CfgW     = 9;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  localparam logic [CfgW-1:0] PoolChunksRst = 9'd256;

  localparam logic [FuncW-1:0] FnInit  = 3'd0;
  localparam logic [FuncW-1:0] FnAlloc = 3'd1;
  localparam logic [FuncW-1:0] FnFree  = 3'd2;
  localparam logic [FuncW-1:0] FnFind  = 3'd3;
  localparam logic [FuncW-1:0] FnSize  = 3'd4;

  localparam logic [1:0] KindFree     = 2'd0;
  localparam logic [1:0] KindAlloc    = 2'd1;
  localparam logic [1:0] KindInterior = 2'd2;
  localparam logic [1:0] KindOutside  = 2'd3;

  localparam logic [ApbAddrW-3:0] RegPoolChunks = '0;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_BAD_REQ   = 3'd2,
    ST_NOT_ALLOC = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [ReqW-1:0]  request_bytes;
    logic [OffW-1:0]  address_offset;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [StartW-1:0]  span_start_chunk;
    logic [BytesW-1:0]  span_bytes;
    logic [BytesW-1:0]  bytes_allocated;
    logic [BytesW-1:0]  max_bytes_allocated;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_INIT_START,
    OP_SWEEP,
    OP_FAIL,
    OP_A_START,
    OP_HEAD_RD,
    OP_LIST_NEXT,
    OP_NODE_FIRST,
    OP_NODE_NEXT,
    OP_FOUND,
    OP_R1,
    OP_R2,
    OP_R3,
    OP_I1,
    OP_I2,
    OP_I3,
    OP_F1,
    OP_MARK,
    OP_ACCOUNT,
    OP_X_SIZE,
    OP_X_FREE,
    OP_X_OWNER,
    OP_H_OK,
    OP_LOAD_OUT
  } op_e;

  typedef struct packed {
    op_e     op;
    status_e fail_status;
  } cmd_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic req_zero;
    logic too_big;
    logic idx_oor;
    logic sweep_last;
    logic head_nil;
    logic lst_last;
    logic node_fits;
    logic next_more;
    logic residue;
    logic mark_more;
    logic x_alloc_ok;
    logic kind_alloc;
    logic kind_int;
    logic owner_in;
    logic h_ok;
  } sts_t;

endpackage

### sv/ssca_ctrl.sv
module ssca_ctrl import ssca_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output logic in_stall_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  typedef enum logic [16:0] {
    S_SWEEP  = 17'h00001,
    S_IDLE   = 17'h00002,
    S_DECODE = 17'h00004,
    S_A_HRD  = 17'h00008,
    S_A_HCHK = 17'h00010,
    S_A_NCHK = 17'h00020,
    S_R1     = 17'h00040,
    S_R2     = 17'h00080,
    S_R3     = 17'h00100,
    S_I1     = 17'h00200,
    S_I2     = 17'h00400,
    S_I3     = 17'h00800,
    S_F1     = 17'h01000,
    S_MARK   = 17'h02000,
    S_X_CHK  = 17'h04000,
    S_H_CHK  = 17'h08000,
    S_DONE   = 17'h10000
  } state_e;

  state_e state_q, state_d;
  logic   reply_q, reply_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    reply_d = reply_q;
    cmd_o   = '{op: OP_NONE, fail_status: ST_OK};
    unique case (state_q)
      S_SWEEP: begin
        cmd_o.op = OP_SWEEP;
        if (sts_i.sweep_last) begin
          state_d = reply_q ? S_DONE : S_IDLE;
          reply_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.func) inside
          FnInit: begin
            cmd_o.op = OP_INIT_START;
            reply_d  = 1'b1;
            state_d  = S_SWEEP;
          end
          FnAlloc: begin
            if (sts_i.req_zero) begin
              cmd_o   = '{op: OP_FAIL, fail_status: ST_BAD_REQ};
              state_d = S_DONE;
            end else if (sts_i.too_big) begin
              cmd_o   = '{op: OP_FAIL, fail_status: ST_NO_SPACE};
              state_d = S_DONE;
            end else begin
              cmd_o.op = OP_A_START;
              state_d  = S_A_HRD;
            end
          end
          FnFree, FnFind, FnSize: begin
            // chunk entry of the offset is read in this cycle
            if (sts_i.idx_oor) begin
              cmd_o   = '{op: OP_FAIL, fail_status: ST_RANGE};
              state_d = S_DONE;
            end else begin
              state_d = S_X_CHK;
            end
          end
          default: begin
            cmd_o   = '{op: OP_FAIL, fail_status: ST_BAD_REQ};
            state_d = S_DONE;
          end
        endcase
      end
      S_A_HRD: begin
        cmd_o.op = OP_HEAD_RD;
        state_d  = S_A_HCHK;
      end
      S_A_HCHK: begin
        if (!sts_i.head_nil) begin
          cmd_o.op = OP_NODE_FIRST;
          state_d  = S_A_NCHK;
        end else if (sts_i.lst_last) begin
          cmd_o   = '{op: OP_FAIL, fail_status: ST_NO_SPACE};
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_LIST_NEXT;
          state_d  = S_A_HRD;
        end
      end
      S_A_NCHK: begin
        if (sts_i.node_fits) begin
          cmd_o.op = OP_FOUND;
          state_d  = S_R1;
        end else if (sts_i.next_more) begin
          cmd_o.op = OP_NODE_NEXT;
        end else if (sts_i.lst_last) begin
          cmd_o   = '{op: OP_FAIL, fail_status: ST_NO_SPACE};
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_LIST_NEXT;
          state_d  = S_A_HRD;
        end
      end
      S_R1: begin
        cmd_o.op = OP_R1;
        state_d  = S_R2;
      end
      S_R2: begin
        cmd_o.op = OP_R2;
        state_d  = S_R3;
      end
      S_R3: begin
        cmd_o.op = OP_R3;
        state_d  = sts_i.residue ? S_I1 : S_F1;
      end
      S_I1: begin
        cmd_o.op = OP_I1;
        state_d  = S_I2;
      end
      S_I2: begin
        cmd_o.op = OP_I2;
        state_d  = S_I3;
      end
      S_I3: begin
        cmd_o.op = OP_I3;
        state_d  = (sts_i.func == FnAlloc) ? S_F1 : S_DONE;
      end
      S_F1: begin
        cmd_o.op = OP_F1;
        state_d  = S_MARK;
      end
      S_MARK: begin
        if (sts_i.mark_more) begin
          cmd_o.op = OP_MARK;
        end else begin
          cmd_o.op = OP_ACCOUNT;
          state_d  = S_DONE;
        end
      end
      S_X_CHK: begin
        if (sts_i.func == FnFind) begin
          if (sts_i.kind_alloc) begin
            cmd_o.op = OP_X_SIZE;
            state_d  = S_DONE;
          end else if (sts_i.kind_int && sts_i.owner_in) begin
            cmd_o.op = OP_X_OWNER;
            state_d  = S_H_CHK;
          end else begin
            cmd_o   = '{op: OP_FAIL, fail_status: ST_NOT_ALLOC};
            state_d = S_DONE;
          end
        end else if (!sts_i.x_alloc_ok) begin
          cmd_o   = '{op: OP_FAIL, fail_status: ST_NOT_ALLOC};
          state_d = S_DONE;
        end else if (sts_i.func == FnFree) begin
          cmd_o.op = OP_X_FREE;
          state_d  = S_I1;
        end else begin
          cmd_o.op = OP_X_SIZE;
          state_d  = S_DONE;
        end
      end
      S_H_CHK: begin
        if (sts_i.h_ok) begin
          cmd_o.op = OP_H_OK;
        end else begin
          cmd_o = '{op: OP_FAIL, fail_status: ST_NOT_ALLOC};
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o.op = OP_LOAD_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == OP_LOAD_OUT) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      reply_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      reply_q     <= reply_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### sv/ssca_dp.sv
module ssca_dp import ssca_pkg::*; #(
  parameter int NumChunks = NumChunksDef,
  parameter int NumLists  = NumListsDef,
  parameter int ChunkLog2 = ChunkLog2Def
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  input  in_item_t        in_item_i,
  input  logic [CfgW-1:0] pool_chunks_i,
  output sts_t            sts_o,
  output out_item_t       out_item_o
);

  localparam int CW   = $clog2(NumChunks);
  localparam int PW   = $clog2(NumChunks + 1);
  localparam int LW   = $clog2(NumLists);
  localparam int MaxE = (NumChunks > NumLists) ? NumChunks : NumLists;
  localparam int SWW  = $clog2(MaxE);
  localparam int IW   = OffW - ChunkLog2;
  localparam int CBW  = ReqW + 1 - ChunkLog2;
  localparam logic [PW-1:0] Nil = PW'(NumChunks);

  function automatic logic [LW-1:0] lidx(input logic [PW-1:0] n);
    logic [LW-1:0] r;
    if (n == '0) begin
      r = '0;
    end else if (n < NumLists) begin
      r = LW'(n - 1'b1);
    end else begin
      r = LW'(NumLists - 1);
    end
    return r;
  endfunction

  function automatic logic [PW-1:0] clamp(input logic [CfgW-1:0] v);
    logic [PW-1:0] r;
    if (v == '0) begin
      r = PW'(1);
    end else if (v > NumChunks) begin
      r = PW'(NumChunks);
    end else begin
      r = PW'(v);
    end
    return r;
  endfunction

  function automatic logic [BytesW-1:0] bytes_of(input logic [PW-1:0] n);
    return BytesW'(n) << ChunkLog2;
  endfunction

  // storage
  logic [1:0]    kind_mem  [NumChunks];
  logic [PW-1:0] len_mem   [NumChunks];
  logic [PW-1:0] prev_mem  [NumChunks];
  logic [PW-1:0] next_mem  [NumChunks];
  logic [CW-1:0] owner_mem [NumChunks];
  logic [PW-1:0] head_mem  [NumLists];

  logic [1:0]    kind_rd;
  logic [PW-1:0] len_rd, prev_rd, next_rd, head_rd;
  logic [CW-1:0] owner_rd;

  logic [CW-1:0] rd_addr;
  logic [LW-1:0] head_ra;

  logic          kind_we, len_we, prev_we, next_we, owner_we, head_we;
  logic [CW-1:0] kind_wa, len_wa, prev_wa, next_wa, owner_wa;
  logic [LW-1:0] head_wa;
  logic [1:0]    kind_wd;
  logic [PW-1:0] len_wd, prev_wd, next_wd, head_wd;
  logic [CW-1:0] owner_wd;

  // item and working registers
  logic [FuncW-1:0]  func_q;
  logic [ReqW-1:0]   req_q;
  logic [OffW-1:0]   off_q;
  logic [PW-1:0]     pool_size_q;
  logic [BytesW-1:0] alloc_q, peak_q;
  logic [SWW-1:0]    sweep_q;
  logic [LW-1:0]     lst_q;
  logic [CW-1:0]     cur_q, found_q, ins_x_q, h_q;
  logic [PW-1:0]     guard_q, flen_q, fprev_q, fnext_q, c_q, ins_len_q, ins_h_q, i_q;
  status_e           res_status_q;
  logic [CW-1:0]     res_start_q;
  logic [BytesW-1:0] res_bytes_q;
  out_item_t         out_q;

  logic [IW-1:0]       idx;
  logic [IW+CW-1:0]    idx_ext;
  logic [CW-1:0]       x;
  logic                aligned;
  logic [ReqW:0]       req_sum;
  logic [CBW-1:0]      cfull;
  logic [PW:0]         fc, mi;
  logic [BytesW-1:0]   alloc_add, x_bytes;
  logic [CW+StartW-1:0] start_ext;

  assign idx     = off_q[OffW-1:ChunkLog2];
  assign idx_ext = {{CW{1'b0}}, idx};
  assign x       = idx_ext[CW-1:0];
  assign aligned = (off_q[ChunkLog2-1:0] == '0);
  assign req_sum = {1'b0, req_q} + ((ReqW+1)'(1) << ChunkLog2) - (ReqW+1)'(1);
  assign cfull   = req_sum[ReqW:ChunkLog2];
  assign fc      = (PW+1)'(found_q) + (PW+1)'(c_q);
  assign mi      = (PW+1)'(found_q) + (PW+1)'(i_q);
  assign alloc_add = alloc_q + bytes_of(c_q);
  assign x_bytes   = bytes_of(len_rd);
  assign start_ext = {{StartW{1'b0}}, res_start_q};

  always_comb begin
    sts_o            = '0;
    sts_o.func       = func_q;
    sts_o.req_zero   = (req_q == '0);
    sts_o.too_big    = (cfull > NumChunks);
    sts_o.idx_oor    = (idx >= pool_size_q);
    sts_o.sweep_last = (sweep_q == SWW'(MaxE - 1));
    sts_o.head_nil   = !(head_rd < Nil);
    sts_o.lst_last   = (lst_q == LW'(NumLists - 1));
    sts_o.node_fits  = (len_rd >= c_q);
    sts_o.next_more  = (next_rd < Nil) && (guard_q < PW'(NumChunks - 1));
    sts_o.residue    = (flen_q > c_q) && (fc < (PW+1)'(NumChunks));
    sts_o.mark_more  = (i_q < c_q) && (mi < (PW+1)'(NumChunks));
    sts_o.x_alloc_ok = aligned && (kind_rd == KindAlloc);
    sts_o.kind_alloc = (kind_rd == KindAlloc);
    sts_o.kind_int   = (kind_rd == KindInterior);
    sts_o.owner_in   = (PW'(owner_rd) < pool_size_q);
    sts_o.h_ok       = (kind_rd == KindAlloc) &&
                       ((PW+1)'(x) < (PW+1)'(h_q) + (PW+1)'(len_rd));
  end

  // read addresses; pointer reads forward straight from the read data
  always_comb begin
    case (cmd_i.op)
      OP_NODE_FIRST: rd_addr = head_rd[CW-1:0];
      OP_NODE_NEXT:  rd_addr = next_rd[CW-1:0];
      OP_X_OWNER:    rd_addr = owner_rd;
      default:       rd_addr = x;
    endcase
    case (cmd_i.op)
      OP_R1:   head_ra = lidx(flen_q);
      OP_I1:   head_ra = lidx(ins_len_q);
      default: head_ra = lst_q;
    endcase
  end

  always_comb begin
    kind_we  = 1'b0; kind_wa  = '0; kind_wd  = KindFree;
    len_we   = 1'b0; len_wa   = '0; len_wd   = '0;
    prev_we  = 1'b0; prev_wa  = '0; prev_wd  = Nil;
    next_we  = 1'b0; next_wa  = '0; next_wd  = Nil;
    owner_we = 1'b0; owner_wa = '0; owner_wd = '0;
    head_we  = 1'b0; head_wa  = '0; head_wd  = Nil;
    case (cmd_i.op)
      OP_SWEEP: begin
        if (sweep_q < NumChunks) begin
          kind_we  = 1'b1;
          kind_wa  = sweep_q[CW-1:0];
          if (sweep_q == '0) begin
            kind_wd = KindFree;
          end else if (sweep_q < pool_size_q) begin
            kind_wd = KindInterior;
          end else begin
            kind_wd = KindOutside;
          end
          len_we   = 1'b1;
          len_wa   = sweep_q[CW-1:0];
          len_wd   = (sweep_q == '0) ? pool_size_q : '0;
          prev_we  = 1'b1;
          prev_wa  = sweep_q[CW-1:0];
          next_we  = 1'b1;
          next_wa  = sweep_q[CW-1:0];
          owner_we = 1'b1;
          owner_wa = sweep_q[CW-1:0];
        end
        if (sweep_q < NumLists) begin
          head_we = 1'b1;
          head_wa = sweep_q[LW-1:0];
          head_wd = (sweep_q == lidx(pool_size_q)) ? '0 : Nil;
        end
      end
      OP_R1: begin
        next_we = (fprev_q < Nil);
        next_wa = fprev_q[CW-1:0];
        next_wd = fnext_q;
      end
      OP_R2: begin
        prev_we = (fnext_q < Nil);
        prev_wa = fnext_q[CW-1:0];
        prev_wd = fprev_q;
        head_we = (head_rd == PW'(found_q));
        head_wa = lidx(flen_q);
        head_wd = fnext_q;
      end
      OP_R3: begin
        prev_we = 1'b1;
        prev_wa = found_q;
        next_we = 1'b1;
        next_wa = found_q;
      end
      OP_I1: begin
        kind_we = 1'b1;
        kind_wa = ins_x_q;
        kind_wd = KindFree;
        len_we  = 1'b1;
        len_wa  = ins_x_q;
        len_wd  = ins_len_q;
      end
      OP_I2: begin
        prev_we = 1'b1;
        prev_wa = ins_x_q;
        next_we = 1'b1;
        next_wa = ins_x_q;
        next_wd = head_rd;
        head_we = 1'b1;
        head_wa = lidx(ins_len_q);
        head_wd = PW'(ins_x_q);
      end
      OP_I3: begin
        prev_we = (ins_h_q < Nil);
        prev_wa = ins_h_q[CW-1:0];
        prev_wd = PW'(ins_x_q);
      end
      OP_F1: begin
        kind_we = 1'b1;
        kind_wa = found_q;
        kind_wd = KindAlloc;
        len_we  = 1'b1;
        len_wa  = found_q;
        len_wd  = c_q;
      end
      OP_MARK: begin
        kind_we  = 1'b1;
        kind_wa  = mi[CW-1:0];
        kind_wd  = KindInterior;
        owner_we = 1'b1;
        owner_wa = mi[CW-1:0];
        owner_wd = found_q;
        prev_we  = 1'b1;
        prev_wa  = mi[CW-1:0];
        next_we  = 1'b1;
        next_wa  = mi[CW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (kind_we) kind_mem[kind_wa] <= kind_wd;
    kind_rd <= kind_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) len_mem[len_wa] <= len_wd;
    len_rd <= len_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (owner_we) owner_mem[owner_wa] <= owner_wd;
    owner_rd <= owner_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end

  // pool size, counters and sweep pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= clamp(PoolChunksRst);
      alloc_q     <= '0;
      peak_q      <= '0;
      sweep_q     <= '0;
    end else begin
      case (cmd_i.op)
        OP_INIT_START: begin
          pool_size_q <= clamp(pool_chunks_i);
          alloc_q     <= '0;
          peak_q      <= '0;
          sweep_q     <= '0;
        end
        OP_SWEEP: sweep_q <= sweep_q + 1'b1;
        OP_ACCOUNT: begin
          alloc_q <= alloc_add;
          if (alloc_add > peak_q) begin
            peak_q <= alloc_add;
          end
        end
        OP_X_FREE: alloc_q <= (alloc_q >= x_bytes) ? alloc_q - x_bytes : '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin
        func_q       <= in_item_i.func;
        req_q        <= in_item_i.request_bytes;
        off_q        <= in_item_i.address_offset;
        res_status_q <= ST_OK;
        res_start_q  <= '0;
        res_bytes_q  <= '0;
      end
      OP_FAIL: begin
        res_status_q <= cmd_i.fail_status;
        res_start_q  <= '0;
        res_bytes_q  <= '0;
      end
      OP_A_START: begin
        c_q   <= PW'(cfull);
        lst_q <= lidx(PW'(cfull));
      end
      OP_LIST_NEXT: lst_q <= lst_q + 1'b1;
      OP_NODE_FIRST: begin
        cur_q   <= head_rd[CW-1:0];
        guard_q <= '0;
      end
      OP_NODE_NEXT: begin
        cur_q   <= next_rd[CW-1:0];
        guard_q <= guard_q + 1'b1;
      end
      OP_FOUND: begin
        found_q <= cur_q;
        flen_q  <= len_rd;
        fprev_q <= prev_rd;
        fnext_q <= next_rd;
      end
      OP_R3: begin
        ins_x_q   <= fc[CW-1:0];
        ins_len_q <= flen_q - c_q;
      end
      OP_I2: ins_h_q <= head_rd;
      OP_F1: i_q <= PW'(1);
      OP_MARK: i_q <= i_q + 1'b1;
      OP_ACCOUNT: begin
        res_start_q <= found_q;
        res_bytes_q <= bytes_of(c_q);
      end
      OP_X_SIZE: begin
        res_start_q <= x;
        res_bytes_q <= x_bytes;
      end
      OP_X_FREE: begin
        res_start_q <= x;
        res_bytes_q <= x_bytes;
        ins_x_q     <= x;
        ins_len_q   <= len_rd;
      end
      OP_X_OWNER: h_q <= owner_rd;
      OP_H_OK: begin
        res_start_q <= h_q;
        res_bytes_q <= x_bytes;
      end
      OP_LOAD_OUT: begin
        out_q.status              <= res_status_q;
        out_q.span_start_chunk    <= start_ext[StartW-1:0];
        out_q.span_bytes          <= res_bytes_q;
        out_q.bytes_allocated     <= alloc_q;
        out_q.max_bytes_allocated <= peak_q;
      end
      default: ;
    endcase
  end

  assign out_item_o = out_q;

endmodule

### sv/segregated_span_chunk_allocator_core.sv
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  in_item_t  (func, request_bytes, address_offset)
// out      output     out_valid_o / out_stall_i out_item_t (status, span, byte counters)
// cfg      input      APB psel/penable/pwrite  pool_chunks at byte address 0
//
// One item at a time: the block takes no new item before it is through with the last.
// Allocate searches the lists from the request's size class upward, one span at a
// time, splits off any residue and then marks each further chunk of the granted
// span; init sweeps every chunk and list entry.
// The result becomes valid in the same cycle in which the next item can be taken in.
// After reset the init sweep runs before the first item is accepted.
// A stalled result holds the next one in S_DONE; input stalls until it is loaded.
module segregated_span_chunk_allocator_core import ssca_pkg::*; #(
  parameter int NumChunks = NumChunksDef,
  parameter int NumLists  = NumListsDef,
  parameter int ChunkLog2 = ChunkLog2Def
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [CfgW-1:0] pool_chunks_q;
  cmd_t            cmd;
  sts_t            sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_chunks_q <= PoolChunksRst;
    end else if (psel && penable && pwrite && paddr[ApbAddrW-1:2] == RegPoolChunks) begin
      pool_chunks_q <= pwdata[CfgW-1:0];
    end
  end

  assign prdata = (paddr[ApbAddrW-1:2] == RegPoolChunks) ? ApbDataW'(pool_chunks_q) : '0;
  assign pready = 1'b1;

  ssca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  ssca_dp #(
    .NumChunks (NumChunks),
    .NumLists  (NumLists),
    .ChunkLog2 (ChunkLog2)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_item_i     (in_item_i),
    .pool_chunks_i (pool_chunks_q),
    .sts_o         (sts),
    .out_item_o    (out_item_o)
  );

endmodule

### sv/ssca_chk.sv
module ssca_chk import ssca_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while previous still in work");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK |->
      out_item_o.span_bytes == '0 && out_item_o.span_start_chunk == '0)
    else $error("failed item carries a span");

  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.bytes_allocated <= out_item_o.max_bytes_allocated)
    else $error("allocated bytes above high-water mark");

endmodule

bind segregated_span_chunk_allocator_core ssca_chk u_ssca_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

### bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssca_pkg::*;

  localparam int NCH = 256;
  localparam int NIL = 256;
  localparam int CLOG = 19;
  localparam int WDOG_LIMIT = 40000;

  // Span allocator predictor: segregated free lists, no coalescing.
  class span_pool_sb;
    int unsigned pool_reg;
    int unsigned pool_size;
    int unsigned head_of[NCH];
    int unsigned kind[NCH];
    int unsigned slen[NCH];
    int unsigned prv[NCH];
    int unsigned nxt[NCH];
    int unsigned owner[NCH];
    logic [27:0] alloc_b;
    logic [27:0] peak_b;
    out_item_t pending[$];
    int errors;

    function new();
      pool_reg = 256;
      errors = 0;
      pool_init();
    endfunction

    function int unsigned lidx(int unsigned n);
      if (n == 0) return 0;
      return (n < NCH) ? n - 1 : NCH - 1;
    endfunction

    function void link_in(int unsigned x);
      int unsigned l;
      int unsigned h;
      l = lidx(slen[x]);
      h = head_of[l];
      prv[x] = NIL;
      nxt[x] = h;
      if (h < NCH) prv[h] = x;
      head_of[l] = x;
    endfunction

    function void unlink(int unsigned x);
      int unsigned p;
      int unsigned n;
      int unsigned l;
      p = prv[x];
      n = nxt[x];
      l = lidx(slen[x]);
      if (p < NCH) nxt[p] = n;
      if (n < NCH) prv[n] = p;
      if (head_of[l] == x) head_of[l] = n;
      prv[x] = NIL;
      nxt[x] = NIL;
    endfunction

    function void pool_init();
      int unsigned n;
      n = pool_reg;
      if (n < 1) n = 1;
      if (n > NCH) n = NCH;
      pool_size = n;
      for (int i = 0; i < NCH; i++) begin
        head_of[i] = NIL;
        kind[i] = (i == 0) ? KindFree : (i < n ? KindInterior : KindOutside);
        slen[i] = 0;
        prv[i] = NIL;
        nxt[i] = NIL;
        owner[i] = 0;
      end
      slen[0] = n;
      alloc_b = '0;
      peak_b = '0;
      link_in(0);
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      status_e st;
      int unsigned start;
      longint unsigned bytes;
      longint unsigned req;
      longint unsigned idx;
      int unsigned c;
      int unsigned found;
      int unsigned cur;
      int unsigned g;
      int unsigned x;
      int unsigned h;
      bit aligned;
      st = ST_OK;
      start = 0;
      bytes = 0;
      req = it.request_bytes;
      idx = it.address_offset >> CLOG;
      aligned = it.address_offset[CLOG-1:0] == '0;
      case (it.func)
        FnInit: pool_init();
        FnAlloc: begin
          c = 32'((req + (64'd1 << CLOG) - 1) >> CLOG);
          if (req == 0) st = ST_BAD_REQ;
          else if (c > NCH) st = ST_NO_SPACE;
          else begin
            found = NIL;
            for (int l = lidx(c); l < NCH && found == NIL; l++) begin
              cur = head_of[l];
              g = 0;
              while (cur < NCH && g < NCH) begin
                if (slen[cur] >= c) begin
                  found = cur;
                  break;
                end
                cur = nxt[cur];
                g++;
              end
            end
            if (found >= NCH) st = ST_NO_SPACE;
            else begin
              x = slen[found];
              unlink(found);
              if (x > c && found + c < NCH) begin
                slen[found + c] = x - c;
                kind[found + c] = KindFree;
                link_in(found + c);
              end
              slen[found] = c;
              for (int i = 1; i < c && found + i < NCH; i++) begin
                kind[found + i] = KindInterior;
                owner[found + i] = found;
                prv[found + i] = NIL;
                nxt[found + i] = NIL;
              end
              kind[found] = KindAlloc;
              start = found;
              bytes = longint'(c) << CLOG;
              alloc_b = alloc_b + bytes[27:0];
              if (alloc_b > peak_b) peak_b = alloc_b;
            end
          end
        end
        FnFree, FnSize: begin
          if (idx >= pool_size) st = ST_RANGE;
          else begin
            x = 32'(idx);
            if (!aligned || kind[x] != KindAlloc) st = ST_NOT_ALLOC;
            else begin
              start = x;
              bytes = longint'(slen[x]) << CLOG;
              if (it.func == FnFree) begin
                alloc_b = (alloc_b >= bytes) ? alloc_b - bytes[27:0] : '0;
                kind[x] = KindFree;
                link_in(x);
              end
            end
          end
        end
        FnFind: begin
          if (idx >= pool_size) st = ST_RANGE;
          else begin
            x = 32'(idx);
            if (kind[x] == KindAlloc) begin
              start = x;
              bytes = longint'(slen[x]) << CLOG;
            end else if (kind[x] == KindInterior) begin
              h = owner[x];
              if (h < pool_size && kind[h] == KindAlloc && x < h + slen[h]) begin
                start = h;
                bytes = longint'(slen[h]) << CLOG;
              end else st = ST_NOT_ALLOC;
            end else st = ST_NOT_ALLOC;
          end
        end
        default: st = ST_BAD_REQ;
      endcase
      if (st != ST_OK) begin
        start = 0;
        bytes = 0;
      end
      r.status = st;
      r.span_start_chunk = start[7:0];
      r.span_bytes = bytes[27:0];
      r.bytes_allocated = alloc_b;
      r.max_bytes_allocated = peak_b;
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.span_start_chunk !== e.span_start_chunk) begin
        $error("span_start_chunk exp %0d got %0d", e.span_start_chunk,
               got.span_start_chunk); errors++;
      end
      if (got.span_bytes !== e.span_bytes) begin
        $error("span_bytes exp %0h got %0h", e.span_bytes, got.span_bytes); errors++;
      end
      if (got.bytes_allocated !== e.bytes_allocated) begin
        $error("bytes_allocated exp %0h got %0h", e.bytes_allocated,
               got.bytes_allocated); errors++;
      end
      if (got.max_bytes_allocated !== e.max_bytes_allocated) begin
        $error("max_bytes_allocated exp %0h got %0h", e.max_bytes_allocated,
               got.max_bytes_allocated); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  segregated_span_chunk_allocator_core uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  span_pool_sb sb = new();
  int idle_cycles = 0;
  int unsigned live_heads[$];

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_item(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stalls, with quiet stretches
  initial begin
    int unsigned n;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 9) < 3) begin
        n = $urandom_range(20, 120);
        out_stall_i <= 1'b0;
        repeat (n) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat (gap_len()) @(negedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
  end

  // valid stays high after an item until the next call or drain lowers it
  task automatic send(logic [2:0] f, logic [27:0] req, logic [26:0] off);
    int unsigned g;
    g = gap_len();
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_item_i <= '{func: f, request_bytes: req, address_offset: off};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
  endtask

  task automatic write_pool(int unsigned v);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.pool_reg = v & 9'h1ff;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic [27:0] rnd_req();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 28'($urandom_range(1, 4 << CLOG));
    if (r < 8) return 28'($urandom_range(1, 40 << CLOG));
    return 28'($urandom());
  endfunction

  task automatic random_phase(int cnt);
    int unsigned r;
    int unsigned k;
    logic [26:0] off;
    for (int i = 0; i < cnt; i++) begin
      r = $urandom_range(0, 99);
      off = 27'($urandom());
      if (live_heads.size() > 0 && r < 70) begin
        k = $urandom_range(0, live_heads.size() - 1);
        off = 27'((live_heads[k] << CLOG) | (($urandom_range(0, 3) == 0) ?
              $urandom_range(0, 3 << CLOG) : 0));
      end else if (r < 85) off = 27'($urandom_range(0, 300) << CLOG);
      r = $urandom_range(0, 99);
      if (r < 45) send(FnAlloc, rnd_req(), off);
      else if (r < 65) begin
        send(FnFree, '0, off);
        if (live_heads.size() > 0 && $urandom_range(0, 1)) live_heads.delete(0);
      end else if (r < 80) send(FnFind, 28'($urandom()), off);
      else if (r < 93) send(FnSize, 28'($urandom()), off);
      else if (r < 96) begin
        send(FnInit, 28'($urandom()), off);
        live_heads.delete();
      end else send(3'($urandom_range(5, 7)), 28'($urandom()), 27'($urandom()));
      // remember heads granted from predictor state
      for (int c = 0; c < 4; c++) begin
        k = $urandom_range(0, NCH - 1);
        if (sb.kind[k] == KindAlloc && live_heads.size() < 32) live_heads.push_back(k);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, every function, each misuse case
    send(FnAlloc, '0, '0);
    send(FnAlloc, 28'hfffffff, '0);
    send(FnAlloc, 28'd134217728, '0);
    send(FnAlloc, 28'd1, 27'h7ffffff);
    send(FnAlloc, 28'd524288, '0);
    send(FnAlloc, 28'd524289, '0);
    send(FnFind, '0, 27'd1 << CLOG);
    send(FnFind, '0, (27'd2 << CLOG) + 27'd77);
    send(FnSize, '0, 27'd1 << CLOG);
    send(FnSize, '0, (27'd1 << CLOG) + 27'd1);
    send(FnSize, '0, 27'd0);
    send(FnFree, '0, 27'd3 << CLOG);
    send(FnFree, '0, 27'd1 << CLOG);
    send(FnFree, '0, 27'd1 << CLOG);
    send(FnFind, '0, 27'd1 << CLOG);
    send(FnFind, '0, 27'd200 << CLOG);
    send(FnFree, '0, 27'h7ffffff);
    send(FnFind, '0, 27'd256 << CLOG);
    send(FnSize, '0, 27'h7ffffff);
    send(3'd5, '0, '0);
    send(3'd7, 28'hfffffff, 27'h7ffffff);
    send(FnAlloc, 28'd125 << CLOG, '0);
    send(FnAlloc, 28'd200 << CLOG, '0);
    send(FnInit, '0, '0);
    random_phase(150);
    write_pool(1);
    send(FnInit, '0, '0);
    send(FnAlloc, 28'd1, '0);
    send(FnAlloc, 28'd1, '0);
    random_phase(40);
    write_pool(0);
    send(FnInit, '0, '0);
    random_phase(30);
    write_pool(511);
    send(FnInit, '0, '0);
    random_phase(60);
    write_pool(9);
    send(FnInit, '0, '0);
    random_phase(120);
    write_pool(256);
    send(FnInit, '0, '0);
    random_phase(130);
    drain();
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
